/* src/chl_pkg.sv */
// ----------------------------------------------------------------------------
// chl_pkg
// Shared types, constants and helper functions of the token highlight
// classifier: class codes, word limits, keyword table and the command word.
// ----------------------------------------------------------------------------
`default_nettype none

package chl_pkg;

  // byte and word sizing
  localparam int CharW      = 8;
  localparam int HoldMax    = 7;
  localparam int HoldCntW   = $clog2(HoldMax + 1);
  localparam int WordLimit  = 63;
  localparam int WordLenW   = $clog2(WordLimit + 1);
  localparam int MaxResults = HoldMax + 1;
  localparam int IdxW       = $clog2(MaxResults);
  localparam int TotalW     = $clog2(MaxResults + 1);
  localparam int CmdDepth   = 2;
  localparam int CmdPtrW    = $clog2(CmdDepth);
  localparam int CmdCntW    = $clog2(CmdDepth + 1);

  // lexical class codes
  typedef enum logic [2:0] {
    ClsPlain    = 3'd0,
    ClsString   = 3'd1,
    ClsKeyword  = 3'd2,
    ClsOperator = 3'd3,
    ClsDigit    = 3'd4
  } class_e;

  typedef logic [HoldMax-1:0][CharW-1:0] word_t;

  // one command from front to back: release of held word, then current byte
  typedef struct packed {
    logic [HoldCntW-1:0] rel_cnt;
    class_e              rel_cls;
    logic                rel_le;
    word_t               rel_word;
    logic                cur_vld;
    logic [CharW-1:0]    cur_char;
    class_e              cur_cls;
    logic                cur_le;
  } cmd_t;

  // keyword table, text right aligned, first character highest
  localparam int NumKw = 9;
  localparam logic [HoldMax*CharW-1:0] KwText [NumKw] = '{
    "int", "void", "char", "if", "else", "while", "return", "struct", "include"
  };
  localparam logic [HoldCntW-1:0] KwLen [NumKw] = '{
    3'd3, 3'd4, 3'd4, 3'd2, 3'd4, 3'd5, 3'd6, 3'd6, 3'd7
  };

  localparam logic [CharW-1:0] ChQuote = 8'h22;
  localparam logic [CharW-1:0] ChUnder = 8'h5F;

  function automatic logic is_alpha(input logic [CharW-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word(input logic [CharW-1:0] c);
    return is_alpha(c) || is_digit(c) || (c == ChUnder);
  endfunction

  // operators and brackets: { } ( ) [ ] # < > ; = + - * /
  function automatic logic is_op(input logic [CharW-1:0] c);
    logic hit;
    hit = 1'b0;
    case (c) inside
      8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h23, 8'h3C,
      8'h3E, 8'h3B, 8'h3D, 8'h2B, 8'h2D, 8'h2A, 8'h2F: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // held word against the keyword table
  function automatic logic kw_match(input word_t w, input logic [HoldCntW-1:0] cnt);
    logic any;
    logic same;
    int   pos;
    any = 1'b0;
    for (int k = 0; k < NumKw; k++) begin
      same = (KwLen[k] == cnt);
      for (int i = 0; i < HoldMax; i++) begin
        pos = CharW * (int'(KwLen[k]) - 1 - i);
        if (i < int'(KwLen[k])) begin
          if (w[i] != KwText[k][pos +: CharW]) same = 1'b0;
        end
      end
      any = any | same;
    end
    return any;
  endfunction

endpackage

`default_nettype wire

/* src/chl_front.sv */
// ----------------------------------------------------------------------------
// chl_front
// Takes one byte per cycle while the command queue has room, tracks string
// and word state, holds word bytes and issues release/emit commands into it.
// ----------------------------------------------------------------------------
`default_nettype none

module chl_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [chl_pkg::CharW-1:0] in_char_i,
  input  wire logic                      in_le_i,
  input  wire logic                      q_full_i,
  output logic                           q_push_o,
  output chl_pkg::cmd_t                  q_cmd_o
);

  localparam logic [chl_pkg::HoldCntW-1:0] HoldCntOne = 1;
  localparam logic [chl_pkg::WordLenW-1:0] WordLenOne = 1;

  logic                           str_q, str_d;
  logic [chl_pkg::HoldCntW-1:0]   cnt_q, cnt_d;
  logic [chl_pkg::WordLenW-1:0]   len_q, len_d;
  logic                           tl_q, tl_d;
  chl_pkg::word_t                 held_q, held_d;
  chl_pkg::word_t                 word_new;
  chl_pkg::cmd_t                  cmd;
  logic                           take;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign q_push_o   = take && ((cmd.rel_cnt != '0) || cmd.cur_vld);
  assign q_cmd_o    = cmd;

  // classification and next state
  always_comb begin
    str_d    = str_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    tl_d     = tl_q;
    held_d   = held_q;
    word_new = held_q;
    cmd      = '0;
    if (str_q) begin
      cmd.cur_vld  = 1'b1;
      cmd.cur_char = in_char_i;
      cmd.cur_cls  = chl_pkg::ClsString;
      cmd.cur_le   = in_le_i;
      if (in_char_i == chl_pkg::ChQuote || in_le_i) str_d = 1'b0;
    end else if (len_q != '0 && chl_pkg::is_word(in_char_i)) begin
      len_d = len_q + 1'b1;
      if (tl_q) begin
        cmd.cur_vld  = 1'b1;
        cmd.cur_char = in_char_i;
        cmd.cur_cls  = chl_pkg::ClsPlain;
        cmd.cur_le   = in_le_i;
      end else if (cnt_q < chl_pkg::HoldCntW'(chl_pkg::HoldMax)) begin
        word_new[cnt_q] = in_char_i;
        held_d          = word_new;
        cnt_d           = cnt_q + 1'b1;
      end else begin
        // word grows past the hold buffer: flush as plain
        cmd.rel_cnt  = cnt_q;
        cmd.rel_cls  = chl_pkg::ClsPlain;
        cmd.rel_word = held_q;
        cmd.cur_vld  = 1'b1;
        cmd.cur_char = in_char_i;
        cmd.cur_cls  = chl_pkg::ClsPlain;
        cmd.cur_le   = in_le_i;
        cnt_d        = '0;
        tl_d         = 1'b1;
      end
      // word cut at the limit or at line end
      if (len_d >= chl_pkg::WordLenW'(chl_pkg::WordLimit) || in_le_i) begin
        if (cnt_d != '0) begin
          cmd.rel_cnt  = cnt_d;
          cmd.rel_word = word_new;
          cmd.rel_cls  = chl_pkg::kw_match(word_new, cnt_d) ? chl_pkg::ClsKeyword
                                                             : chl_pkg::ClsPlain;
          cmd.rel_le   = in_le_i;
          cnt_d        = '0;
        end
        len_d = '0;
        tl_d  = 1'b0;
      end
    end else begin
      // a non-word byte closes an open word
      if (len_q != '0) begin
        cmd.rel_cnt  = cnt_q;
        cmd.rel_word = held_q;
        cmd.rel_cls  = chl_pkg::kw_match(held_q, cnt_q) ? chl_pkg::ClsKeyword
                                                        : chl_pkg::ClsPlain;
        cnt_d        = '0;
        len_d        = '0;
        tl_d         = 1'b0;
      end
      cmd.cur_char = in_char_i;
      cmd.cur_le   = in_le_i;
      if (in_char_i == chl_pkg::ChQuote) begin
        cmd.cur_vld = 1'b1;
        cmd.cur_cls = chl_pkg::ClsString;
        str_d       = !in_le_i;
      end else if (chl_pkg::is_alpha(in_char_i) || in_char_i == chl_pkg::ChUnder) begin
        held_d[0] = in_char_i;
        cnt_d     = HoldCntOne;
        len_d     = WordLenOne;
        tl_d      = 1'b0;
        if (in_le_i) begin
          // one-letter word on its own at line end
          cmd.cur_vld = 1'b1;
          cmd.cur_cls = chl_pkg::ClsPlain;
          cnt_d       = '0;
          len_d       = '0;
        end
      end else if (chl_pkg::is_op(in_char_i)) begin
        cmd.cur_vld = 1'b1;
        cmd.cur_cls = chl_pkg::ClsOperator;
      end else if (chl_pkg::is_digit(in_char_i)) begin
        cmd.cur_vld = 1'b1;
        cmd.cur_cls = chl_pkg::ClsDigit;
      end else begin
        cmd.cur_vld = 1'b1;
        cmd.cur_cls = chl_pkg::ClsPlain;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_q <= 1'b0;
      cnt_q <= '0;
      len_q <= '0;
      tl_q  <= 1'b0;
    end else if (take) begin
      str_q <= str_d;
      cnt_q <= cnt_d;
      len_q <= len_d;
      tl_q  <= tl_d;
    end
  end

  // held word bytes
  always_ff @(posedge clk_i) begin
    if (take) held_q <= held_d;
  end

  // state consistency checks
  a_held_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> len_q != '0)
    else $error("held bytes without an open word");
  a_long_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tl_q |-> cnt_q == '0)
    else $error("overlong word still holds bytes");
  a_long_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tl_q |-> len_q > chl_pkg::WordLenW'(chl_pkg::HoldMax))
    else $error("overlong flag with short word");
  a_str_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    str_q |-> len_q == '0)
    else $error("word open inside a string");

endmodule

`default_nettype wire

/* src/chl_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// chl_cmd_fifo
// Short command queue between front and back, so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module chl_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire chl_pkg::cmd_t push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               head_vld_o,
  output chl_pkg::cmd_t      head_cmd_o
);

  chl_pkg::cmd_t                 mem_q [chl_pkg::CmdDepth];
  logic [chl_pkg::CmdPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [chl_pkg::CmdCntW-1:0]   cnt_q;
  logic                          do_pop;

  assign full_o     = (cnt_q == chl_pkg::CmdCntW'(chl_pkg::CmdDepth));
  assign head_vld_o = (cnt_q != '0);
  assign head_cmd_o = mem_q[rd_ptr_q];
  assign do_pop     = pop_i && head_vld_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == chl_pkg::CmdPtrW'(chl_pkg::CmdDepth - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == chl_pkg::CmdPtrW'(chl_pkg::CmdDepth - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

`default_nettype wire

/* src/chl_back.sv */
// ----------------------------------------------------------------------------
// chl_back
// Expands one queued command into result words: the released held bytes,
// then the current byte, one word per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module chl_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      head_vld_i,
  input  wire chl_pkg::cmd_t             head_cmd_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [chl_pkg::CharW-1:0]      out_char_o,
  output chl_pkg::class_e                out_cls_o,
  output logic                           out_le_o,
  output logic                           out_last_o
);

  logic [chl_pkg::IdxW-1:0]   idx_q;
  logic [chl_pkg::TotalW-1:0] total;
  logic                       in_rel;
  logic                       fire;

  assign total  = chl_pkg::TotalW'(head_cmd_i.rel_cnt) + chl_pkg::TotalW'(head_cmd_i.cur_vld);
  assign in_rel = chl_pkg::TotalW'(idx_q) < chl_pkg::TotalW'(head_cmd_i.rel_cnt);

  assign out_valid_o = head_vld_i;
  assign out_last_o  = (chl_pkg::TotalW'(idx_q) + 1'b1) == total;
  assign fire        = out_valid_o && out_ready_i;
  assign pop_o       = fire && out_last_o;

  // result word select
  always_comb begin
    if (in_rel) begin
      out_char_o = head_cmd_i.rel_word[idx_q];
      out_cls_o  = head_cmd_i.rel_cls;
      out_le_o   = out_last_o && head_cmd_i.rel_le;
    end else begin
      out_char_o = head_cmd_i.cur_char;
      out_cls_o  = head_cmd_i.cur_cls;
      out_le_o   = head_cmd_i.cur_le;
    end
  end

  // position within the current command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= out_last_o ? '0 : idx_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* src/c_token_highlight_classifier.sv */
// ----------------------------------------------------------------------------
// c_token_highlight_classifier
// Tags each byte of a source line with a lexical class; words are held until
// classified as keyword or plain.
// ----------------------------------------------------------------------------
//  port group | dir | tdata               | tuser                     | tlast
//  s_axis     | in  | text_char [7:0]     | -                         | line_end
//  m_axis     | out | out_char [7:0]      | char_class[2:0],run_last  | out_line_end
//
//  The front takes one byte per cycle whenever the two-entry command queue
//  has room; bytes that only extend a held word leave no command.
//  The back sends one result word per cycle while m_axis_tready is high;
//  an item yields up to 8 result words when a held word is released.
//  Reset clears string, word and queue state; held word bytes are not cleared.
//  Stalls on m_axis fill the queue and then drop s_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module c_token_highlight_classifier (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] text_char
  input  wire logic       s_axis_tlast,   // line_end
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_char
  output logic [3:0]      m_axis_tuser,   // [2:0] char_class, [3] run_last
  output logic            m_axis_tlast    // out_line_end
);

  logic            q_full;
  logic            q_push;
  chl_pkg::cmd_t   q_cmd;
  logic            q_pop;
  logic            head_vld;
  chl_pkg::cmd_t   head_cmd;
  chl_pkg::class_e out_cls;
  logic            out_last;

  // byte intake and classification
  chl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .in_le_i    (s_axis_tlast),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd)
  );

  // command queue
  chl_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_vld_o (head_vld),
    .head_cmd_o (head_cmd)
  );

  // result expansion
  chl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_cmd_i  (head_cmd),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_cls_o   (out_cls),
    .out_le_o    (m_axis_tlast),
    .out_last_o  (out_last)
  );

  assign m_axis_tuser = {out_last, out_cls};

endmodule

`default_nettype wire
